// ----- hdl/tof_pkg.sv -----
// ----------------------------------------------------------------------------
// tof_pkg
// Shared types and constants of the third-order altitude fusion filter.
// ----------------------------------------------------------------------------
package tof_pkg;

  // number of past estimates kept for the baro error
  localparam int DelayTaps = 3;

  // configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_GAIN_ACCEL    = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_VELOCITY = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_POSITION = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_CALIB_SAMPLES = 4'd3;

  localparam logic [15:0] GainAccelRst    = 16'd1024;
  localparam logic [15:0] GainVelocityRst = 16'd12288;
  localparam logic [15:0] GainPositionRst = 16'd49152;
  localparam logic [9:0]  CalibSamplesRst = 10'd500;

  // shared unit widths
  localparam int MulAW = 35;
  localparam int MulBW = 25;
  localparam int ProdW = MulAW + MulBW;
  localparam int RndW  = 44;
  localparam int AddW  = 49;
  localparam int SumW  = AddW + 1;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [47:0] q32_t;
  typedef logic [23:0]        dt_t;

  typedef struct packed {
    logic [15:0] gain_accel;
    logic [15:0] gain_velocity;
    logic [15:0] gain_position;
    logic [9:0]  calib_samples;
  } cfg_t;

  typedef struct packed {
    q16_t baro_altitude;
    q16_t vertical_accel;
    dt_t  step_time;
  } item_t;

  typedef struct packed {
    q16_t height_estimate;
    q16_t vertical_speed;
    logic calibrating;
  } res_t;

  // request to the shared multiply / add unit
  typedef struct packed {
    logic                    mul_en;
    logic                    shr17;
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic                    sub;
    logic signed [AddW-1:0]  add_a;
    logic signed [AddW-1:0]  add_b;
  } alu_req_t;

  typedef struct packed {
    logic signed [RndW-1:0] mul_res;
    logic signed [SumW-1:0] sum;
    q32_t                   sum_sat48;
    q16_t                   sum_sat32;
  } alu_rsp_t;

endpackage

// ----- hdl/tof_if.sv -----
// ----------------------------------------------------------------------------
// tof_if
// Valid/ready channels of the altitude fusion filter.
// ----------------------------------------------------------------------------
interface tof_in_if;
  import tof_pkg::*;
  logic valid;
  logic ready;
  q16_t baro_altitude;
  q16_t vertical_accel;
  dt_t  step_time;
  modport source (output valid, baro_altitude, vertical_accel, step_time, input ready);
  modport sink   (input valid, baro_altitude, vertical_accel, step_time, output ready);
endinterface

interface tof_out_if;
  import tof_pkg::*;
  logic valid;
  logic ready;
  q16_t height_estimate;
  q16_t vertical_speed;
  logic calibrating;
  modport source (output valid, height_estimate, vertical_speed, calibrating, input ready);
  modport sink   (input valid, height_estimate, vertical_speed, calibrating, output ready);
endinterface

interface tof_cfg_if;
  import tof_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/third_order_altitude_fusion.sv -----
// ----------------------------------------------------------------------------
// third_order_altitude_fusion
// Baro / vertical accelerometer third-order complementary altitude filter.
// ----------------------------------------------------------------------------
// One input item gives one result. A calibration item (while the sample count
// is below calib_samples) latches the ground offset, clears the corrections and
// returns the held outputs with calibrating set. In a tracking item every product
// and sum goes in turn through a single shared multiply-round unit and a single
// saturating adder, eight multiplies and thirteen additions in a row. The input
// is ready only while the sequencer is idle; the result sits in an output
// register until taken, and the sequencer takes no new item until its result
// has been loaded into that register.
// Register writes are taken at any time and go to index 0..3 in the order
// gain_accel, gain_velocity, gain_position, calib_samples; other indexes are
// ignored.
// ----------------------------------------------------------------------------
module third_order_altitude_fusion (
  input logic      clk_i,
  input logic      rst_ni,
  tof_in_if.sink   in_i,
  tof_out_if.source out_o,
  tof_cfg_if.sink  cfg_i
);
  import tof_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res;
  res_t  res_d, res_q;
  logic  res_valid, res_take;
  logic  out_valid_d, out_valid_q;
  logic  core_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_accel    <= GainAccelRst;
      cfg_q.gain_velocity <= GainVelocityRst;
      cfg_q.gain_position <= GainPositionRst;
      cfg_q.calib_samples <= CalibSamplesRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_GAIN_ACCEL:    cfg_q.gain_accel    <= cfg_i.data;
        CFG_GAIN_VELOCITY: cfg_q.gain_velocity <= cfg_i.data;
        CFG_GAIN_POSITION: cfg_q.gain_position <= cfg_i.data;
        CFG_CALIB_SAMPLES: cfg_q.calib_samples <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

  assign item.baro_altitude  = in_i.baro_altitude;
  assign item.vertical_accel = in_i.vertical_accel;
  assign item.step_time      = in_i.step_time;
  assign in_i.ready          = core_ready;

  tof_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (core_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // output register frees the core as soon as the result is loaded
  assign res_take    = res_valid && (!out_valid_q || out_o.ready);
  assign out_valid_d = res_take || (out_valid_q && !out_o.ready);
  assign res_d       = res_take ? res : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.height_estimate = res_q.height_estimate;
  assign out_o.vertical_speed  = res_q.vertical_speed;
  assign out_o.calibrating     = res_q.calibrating;

endmodule

// ----- hdl/tof_alu.sv -----
// ----------------------------------------------------------------------------
// tof_alu
// Shared multiply-round unit with a saturating adder beside it.
// ----------------------------------------------------------------------------
module tof_alu (
  input  logic              clk_i,
  input  tof_pkg::alu_req_t req_i,
  output tof_pkg::alu_rsp_t rsp_o
);
  import tof_pkg::*;

  localparam logic signed [ProdW-1:0] RndHalf16 = ProdW'(1) <<< 15;
  localparam logic signed [ProdW-1:0] RndHalf17 = ProdW'(1) <<< 16;

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic                    shr17_q;
  logic signed [SumW-1:0]  b_eff;

  // rounding constant folded into the multiply, so the shift is only wiring
  assign prod_d = req_i.mul_a * req_i.mul_b + (req_i.shr17 ? RndHalf17 : RndHalf16);

  always_ff @(posedge clk_i) begin
    if (req_i.mul_en) begin
      prod_q  <= prod_d;
      shr17_q <= req_i.shr17;
    end
  end

  always_comb begin
    rsp_o.mul_res = shr17_q ? {prod_q[ProdW-1], prod_q[ProdW-1:17]} : prod_q[ProdW-1:16];
    b_eff         = req_i.sub ? -SumW'(req_i.add_b) : SumW'(req_i.add_b);
    rsp_o.sum     = SumW'(req_i.add_a) + b_eff;

    if ((&rsp_o.sum[SumW-1:47]) || !(|rsp_o.sum[SumW-1:47])) begin
      rsp_o.sum_sat48 = rsp_o.sum[47:0];
    end else begin
      rsp_o.sum_sat48 = rsp_o.sum[SumW-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end

    if ((&rsp_o.sum[SumW-1:31]) || !(|rsp_o.sum[SumW-1:31])) begin
      rsp_o.sum_sat32 = rsp_o.sum[31:0];
    end else begin
      rsp_o.sum_sat32 = rsp_o.sum[SumW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
  end

endmodule

// ----- hdl/tof_core.sv -----
// ----------------------------------------------------------------------------
// tof_core
// Sequencer and filter state; drives the shared unit one operation a cycle while it works on an item.
// ----------------------------------------------------------------------------
module tof_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tof_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tof_pkg::item_t item_i,
  output logic           res_valid_o,
  input  logic           res_take_i,
  output tof_pkg::res_t  res_o
);
  import tof_pkg::*;

  localparam int OpW = 34;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HOFF  = 5'd1;
  localparam logic [4:0] S_ERR   = 5'd2;
  localparam logic [4:0] S_CMUL1 = 5'd3;
  localparam logic [4:0] S_CMUL2 = 5'd4;
  localparam logic [4:0] S_CACC  = 5'd5;
  localparam logic [4:0] S_ACCEL = 5'd6;
  localparam logic [4:0] S_ASUM  = 5'd7;
  localparam logic [4:0] S_DVMUL = 5'd8;
  localparam logic [4:0] S_DVSAT = 5'd9;
  localparam logic [4:0] S_HSUM  = 5'd10;
  localparam logic [4:0] S_HMUL  = 5'd11;
  localparam logic [4:0] S_HACC  = 5'd12;
  localparam logic [4:0] S_HOUT  = 5'd13;
  localparam logic [4:0] S_SACC  = 5'd14;
  localparam logic [4:0] S_SOUT  = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  // correction slots
  localparam logic [1:0] CORR_ACCEL = 2'd0;
  localparam logic [1:0] CORR_SPEED = 2'd1;
  localparam logic [1:0] CORR_POS   = 2'd2;

  logic [4:0]           state_d, state_q;
  logic [1:0]           idx_d, idx_q;
  item_t                item_d, item_q;
  q16_t                 go_d, go_q;
  logic [9:0]           cnt_d, cnt_q;
  q32_t                 corr_d [3];
  q32_t                 corr_q [3];
  q16_t                 prev_d, prev_q, cur_d, cur_q;
  q32_t                 raw_h_d, raw_h_q, raw_s_d, raw_s_q;
  q16_t                 h_out_d, h_out_q, s_out_d, s_out_q;
  q16_t                 hist_d [DelayTaps];
  q16_t                 hist_q [DelayTaps];
  logic signed [OpW-1:0] op_d, op_q;
  q16_t                 dv_d, dv_q;
  logic                 cal_d, cal_q;
  logic [15:0]          gain_sel;
  alu_req_t             req;
  alu_rsp_t             rsp;

  tof_alu u_alu (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    unique case (idx_q)
      CORR_ACCEL: gain_sel = cfg_i.gain_accel;
      CORR_SPEED: gain_sel = cfg_i.gain_velocity;
      CORR_POS:   gain_sel = cfg_i.gain_position;
      default:    gain_sel = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    item_d  = item_q;
    go_d    = go_q;
    cnt_d   = cnt_q;
    corr_d  = corr_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    raw_h_d = raw_h_q;
    raw_s_d = raw_s_q;
    h_out_d = h_out_q;
    s_out_d = s_out_q;
    hist_d  = hist_q;
    op_d    = op_q;
    dv_d    = dv_q;
    cal_d   = cal_q;
    req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = item_i;
          if (cnt_q < cfg_i.calib_samples) begin
            // ground capture: latch offset, clear corrections, outputs held
            corr_d  = '{default: '0};
            go_d    = item_i.baro_altitude;
            cnt_d   = cnt_q + 10'd1;
            cal_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            cal_d   = 1'b0;
            idx_d   = CORR_ACCEL;
            state_d = S_HOFF;
          end
        end
      end
      S_HOFF: begin
        req.add_a = AddW'(item_q.baro_altitude);
        req.add_b = AddW'(go_q);
        req.sub   = 1'b1;
        op_d      = OpW'(rsp.sum_sat32);
        state_d   = S_ERR;
      end
      S_ERR: begin
        req.add_a = AddW'(op_q);
        req.add_b = AddW'(hist_q[DelayTaps-1]);
        req.sub   = 1'b1;
        op_d      = rsp.sum[OpW-1:0];
        state_d   = S_CMUL1;
      end
      S_CMUL1: begin
        req.mul_en = 1'b1;
        req.mul_a  = MulAW'(op_q);
        req.mul_b  = MulBW'(gain_sel);
        state_d    = S_CMUL2;
      end
      S_CMUL2: begin
        req.mul_en = 1'b1;
        req.mul_a  = rsp.mul_res[MulAW-1:0];
        req.mul_b  = MulBW'(item_q.step_time);
        state_d    = S_CACC;
      end
      S_CACC: begin
        req.add_a     = AddW'(corr_q[idx_q]);
        req.add_b     = AddW'(rsp.mul_res);
        corr_d[idx_q] = rsp.sum_sat48;
        idx_d         = idx_q + 2'd1;
        state_d       = (idx_q == CORR_POS) ? S_ACCEL : S_CMUL1;
      end
      S_ACCEL: begin
        req.add_a = AddW'(item_q.vertical_accel);
        req.add_b = AddW'(corr_q[CORR_ACCEL]);
        prev_d    = cur_q;
        cur_d     = rsp.sum_sat32;
        state_d   = S_ASUM;
      end
      S_ASUM: begin
        req.add_a = AddW'(prev_q);
        req.add_b = AddW'(cur_q);
        op_d      = rsp.sum[OpW-1:0];
        state_d   = S_DVMUL;
      end
      S_DVMUL: begin
        req.mul_en = 1'b1;
        req.shr17  = 1'b1;
        req.mul_a  = MulAW'(op_q);
        req.mul_b  = MulBW'(item_q.step_time);
        state_d    = S_DVSAT;
      end
      S_DVSAT: begin
        req.add_a = AddW'(rsp.mul_res);
        dv_d      = rsp.sum_sat32;
        state_d   = S_HSUM;
      end
      S_HSUM: begin
        // height step uses the speed output of the previous item
        req.add_a = AddW'(s_out_q) <<< 1;
        req.add_b = AddW'(dv_q);
        op_d      = rsp.sum[OpW-1:0];
        state_d   = S_HMUL;
      end
      S_HMUL: begin
        req.mul_en = 1'b1;
        req.shr17  = 1'b1;
        req.mul_a  = MulAW'(op_q);
        req.mul_b  = MulBW'(item_q.step_time);
        state_d    = S_HACC;
      end
      S_HACC: begin
        req.add_a = AddW'(raw_h_q);
        req.add_b = AddW'(rsp.mul_res);
        raw_h_d   = rsp.sum_sat48;
        state_d   = S_HOUT;
      end
      S_HOUT: begin
        req.add_a = AddW'(raw_h_q);
        req.add_b = AddW'(corr_q[CORR_POS]);
        h_out_d   = rsp.sum_sat32;
        for (int i = DelayTaps - 1; i > 0; i--) begin
          hist_d[i] = hist_q[i-1];
        end
        hist_d[0] = rsp.sum_sat32;
        state_d   = S_SACC;
      end
      S_SACC: begin
        req.add_a = AddW'(raw_s_q);
        req.add_b = AddW'(dv_q);
        raw_s_d   = rsp.sum_sat48;
        state_d   = S_SOUT;
      end
      S_SOUT: begin
        req.add_a = AddW'(raw_s_q);
        req.add_b = AddW'(corr_q[CORR_SPEED]);
        s_out_d   = rsp.sum_sat32;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= CORR_ACCEL;
      go_q    <= '0;
      cnt_q   <= '0;
      corr_q  <= '{default: '0};
      prev_q  <= '0;
      cur_q   <= '0;
      raw_h_q <= '0;
      raw_s_q <= '0;
      h_out_q <= '0;
      s_out_q <= '0;
      hist_q  <= '{default: '0};
      cal_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      go_q    <= go_d;
      cnt_q   <= cnt_d;
      corr_q  <= corr_d;
      prev_q  <= prev_d;
      cur_q   <= cur_d;
      raw_h_q <= raw_h_d;
      raw_s_q <= raw_s_d;
      h_out_q <= h_out_d;
      s_out_q <= s_out_d;
      hist_q  <= hist_d;
      cal_q   <= cal_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    op_q   <= op_d;
    dv_q   <= dv_d;
  end

  assign in_ready_o            = (state_q == S_IDLE);
  assign res_valid_o           = (state_q == S_DONE);
  assign res_o.height_estimate = h_out_q;
  assign res_o.vertical_speed  = s_out_q;
  assign res_o.calibrating     = cal_q;

endmodule

// ----- test/tb_third_order_altitude_fusion.sv -----
// ----------------------------------------------------------------------------
// tb_third_order_altitude_fusion
// Self-checking bench for the altitude fusion filter. A short table of directed
// items and register writes comes first, then random phases that each pick new
// gains and a new ground capture length. An in-bench fixed point model predicts the
// results, two directed rows carry their own, and each is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_third_order_altitude_fusion;
  import tof_pkg::*;

  localparam int     ClkHalf       = 6;
  localparam int     SettleCycles  = 30;
  localparam int     RandomPhases  = 8;
  localparam int     PhaseItems    = 100;
  localparam longint TimeoutCycles = 600000;

  localparam longint Max48 = 48'h7FFF_FFFF_FFFF;
  localparam longint Min48 = -Max48 - 1;
  localparam longint Max32 = 32'h7FFF_FFFF;
  localparam longint Min32 = -Max32 - 1;

  // no register sits at this index, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 4'd9;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
    q16_t                baro;
    q16_t                accel;
    dt_t                 dt;
    bit                  typed;
    q16_t                want_alt;
    q16_t                want_spd;
    bit                  want_cal;
  } step_row_t;

  localparam step_row_t Directed[26] = '{
    // first item after reset: capture, outputs still zero
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h03E8_0000, 32'h0000_0000, 24'h01_0000, 1, 0, 0, 1},
    '{ROW_WRITE, CFG_CALIB_SAMPLES, 16'd2, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 1, 0, 0, 1},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h0000_0000, 32'h8000_0000, 24'h00_0000, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h00_0001, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_ACCEL,    16'hFFFF, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_VELOCITY, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_POSITION, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h80_0000, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_ACCEL,    16'h0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_VELOCITY, 16'h0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_POSITION, 16'h0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h0001_0000, 32'h0000_0000, 24'h04_0000, 0, 0, 0, 0},
    // raising the limit above the count resumes ground capture
    '{ROW_WRITE, CFG_CALIB_SAMPLES, 16'h03FF, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h1234_5678, 32'hFFFF_0000, 24'h02_0000, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_CALIB_SAMPLES, 16'h0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_UNUSED,        16'hBEEF, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h1235_0000, 32'h0001_0000, 24'h02_0000, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_ACCEL,    GainAccelRst,    0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_VELOCITY, GainVelocityRst, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, CFG_GAIN_POSITION, GainPositionRst, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  CFG_UNUSED, 16'h0, 32'h1236_0000, 32'h0000_8000, 24'h05_0000, 0, 0, 0, 0}
  };

  logic clk_i;
  logic rst_ni;

  tof_in_if  in_if ();
  tof_out_if out_if ();
  tof_cfg_if cfg_if ();

  third_order_altitude_fusion i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // filter model state
  logic [15:0] gain_acc   = GainAccelRst;
  logic [15:0] gain_vel   = GainVelocityRst;
  logic [15:0] gain_pos   = GainPositionRst;
  logic [9:0]  calib_limit = CalibSamplesRst;
  logic [9:0]  calib_count = '0;
  longint      ground_off = 0;
  longint      corr_acc = 0, corr_spd = 0, corr_hgt = 0;
  longint      acc_prev = 0, acc_now = 0;
  longint      raw_hgt = 0, raw_spd = 0;
  longint      spd_out = 0, hgt_out = 0;
  longint      hgt_hist[DelayTaps] = '{default: 0};

  res_t        estimates_due[$];
  int          mismatches    = 0;
  int          items_sent    = 0;
  int          calib_results = 0;
  int          track_results = 0;
  int          reg_writes    = 0;

  logic [15:0] stall_pattern = '1;
  int          pattern_cycles = 0;

  always begin
    clk_i = 1'b0;
    #ClkHalf;
    clk_i = 1'b1;
    #ClkHalf;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // shift right rounding to nearest, ties upwards
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint integrate_corr(longint acc, longint err, logic [15:0] gain,
                                            longint dt);
    return clamp(acc + round_shift(round_shift(err * longint'(gain), 16) * dt, 16),
                 Min48, Max48);
  endfunction

  function automatic res_t fuse_sample(item_t it);
    longint baro, acc_in, dt, h, err, dv;
    res_t   r;
    baro   = longint'(it.baro_altitude);
    acc_in = longint'(it.vertical_accel);
    dt     = longint'(it.step_time);
    if (calib_count < calib_limit) begin
      corr_acc    = 0;
      corr_spd    = 0;
      corr_hgt    = 0;
      ground_off  = baro;
      calib_count = calib_count + 10'd1;
      r.calibrating = 1'b1;
    end else begin
      h   = clamp(baro - ground_off, Min32, Max32);
      err = h - hgt_hist[DelayTaps-1];
      corr_acc = integrate_corr(corr_acc, err, gain_acc, dt);
      corr_spd = integrate_corr(corr_spd, err, gain_vel, dt);
      corr_hgt = integrate_corr(corr_hgt, err, gain_pos, dt);
      acc_prev = acc_now;
      acc_now  = clamp(acc_in + corr_acc, Min32, Max32);
      dv       = clamp(round_shift((acc_prev + acc_now) * dt, 17), Min32, Max32);
      // height uses the speed output of the previous item
      raw_hgt  = clamp(raw_hgt + round_shift((2 * spd_out + dv) * dt, 17), Min48, Max48);
      hgt_out  = clamp(raw_hgt + corr_hgt, Min32, Max32);
      raw_spd  = clamp(raw_spd + dv, Min48, Max48);
      spd_out  = clamp(raw_spd + corr_spd, Min32, Max32);
      for (int i = DelayTaps - 1; i > 0; i--) hgt_hist[i] = hgt_hist[i-1];
      hgt_hist[0] = hgt_out;
      r.calibrating = 1'b0;
    end
    r.height_estimate = hgt_out[31:0];
    r.vertical_speed  = spd_out[31:0];
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CfgDataW'($urandom() >> $urandom_range(16, 26));
    endcase
  endfunction

  function automatic q16_t pick_edge();
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_item(input item_t it, input bit typed, input res_t want);
    res_t pred;
    @(negedge clk_i);
    in_if.valid          <= 1'b1;
    in_if.baro_altitude  <= it.baro_altitude;
    in_if.vertical_accel <= it.vertical_accel;
    in_if.step_time      <= it.step_time;
    do @(posedge clk_i); while (!in_if.ready);
    pred = fuse_sample(it);
    estimates_due.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // hold the input off until every pending result has been taken
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (estimates_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_GAIN_ACCEL:    gain_acc    = val;
      CFG_GAIN_VELOCITY: gain_vel    = val;
      CFG_GAIN_POSITION: gain_pos    = val;
      CFG_CALIB_SAMPLES: calib_limit = val[9:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // result side: ready follows a rotating stall pattern that is picked anew after a random run
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (pattern_cycles == 0) begin
        pattern_cycles = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0: stall_pattern = '1;
          1: begin
            stall_pattern = 16'($urandom());
            stall_pattern[$urandom_range(0, 15)] = 1'b1;
          end
          default: stall_pattern = 16'h0001 << $urandom_range(0, 15);
        endcase
      end
      out_if.ready   <= stall_pattern[0];
      stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
      pattern_cycles--;
    end
  end

  always @(posedge clk_i) begin : check_result
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (estimates_due.size() == 0) begin
        $error("result with no item pending: height_estimate %0d",
               out_if.height_estimate);
        mismatches++;
      end else begin
        want = estimates_due.pop_front();
        if (out_if.height_estimate !== want.height_estimate) begin
          $error("height_estimate: expected %0d, got %0d",
                 want.height_estimate, out_if.height_estimate);
          mismatches++;
        end
        if (out_if.vertical_speed !== want.vertical_speed) begin
          $error("vertical_speed: expected %0d, got %0d",
                 want.vertical_speed, out_if.vertical_speed);
          mismatches++;
        end
        if (out_if.calibrating !== want.calibrating) begin
          $error("calibrating: expected %0d, got %0d", want.calibrating, out_if.calibrating);
          mismatches++;
        end
        if (want.calibrating) calib_results++;
        else track_results++;
      end
    end
  end

  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    step_row_t   row;
    item_t       stim;
    res_t        typed_res;
    int          burst_left;
    int          gap;
    int          kind;
    int          noisy_from;
    int          walk_alt;
    logic [9:0]  next_limit;

    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.baro_altitude  = '0;
    in_if.vertical_accel = '0;
    in_if.step_time      = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    walk_alt             = 32'h0064_0000;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < $size(Directed); r++) begin
      row = Directed[r];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.wdata);
      end else begin
        stim      = '{row.baro, row.accel, row.dt};
        typed_res = '{row.want_alt, row.want_spd, row.want_cal};
        send_item(stim, row.typed, typed_res);
      end
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      settle();
      write_reg(CFG_GAIN_ACCEL, pick_gain());
      write_reg(CFG_GAIN_VELOCITY, pick_gain());
      write_reg(CFG_GAIN_POSITION, pick_gain());
      case ($urandom_range(0, 3))
        0:       next_limit = '0;
        1:       next_limit = calib_count + 10'($urandom_range(1, 6));
        2:       next_limit = 10'($urandom_range(1, calib_count));
        default: next_limit = 10'd1;
      endcase
      write_reg(CFG_CALIB_SAMPLES, CfgDataW'(next_limit));
      if ($urandom_range(0, 1) == 1)
        write_reg(CfgIdxW'($urandom_range(int'(CFG_CALIB_SAMPLES) + 1, (1 << CfgIdxW) - 1)),
                  CfgDataW'($urandom()));

      // early phases stay mostly well formed, later ones carry more noise
      noisy_from = ph < 5 ? 8 : 5;
      burst_left = 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2 && ph % 2 == 1) settle();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = (ph % 3 == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          if (gap != 0) begin
            @(negedge clk_i);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end
        burst_left--;
        kind = $urandom_range(0, 9);
        if (kind < noisy_from) begin
          walk_alt += int'($urandom_range(0, 100 << 16)) - (50 << 16);
          stim.baro_altitude  = walk_alt;
          stim.vertical_accel = int'($urandom_range(0, 20 << 16)) - (10 << 16);
          stim.step_time      = dt_t'($urandom_range(1 << 16, 20 << 16));
        end else if (kind == 9) begin
          stim.baro_altitude  = pick_edge();
          stim.vertical_accel = pick_edge();
          stim.step_time      = $urandom_range(0, 1) == 1 ? '1 : '0;
        end else begin
          stim.baro_altitude  = q16_t'($urandom());
          stim.vertical_accel = q16_t'($urandom());
          stim.step_time      = dt_t'($urandom());
        end
        send_item(stim, 1'b0, '0);
      end
    end

    settle();
    $display("covered %0d items: %0d ground capture and %0d tracking results",
             items_sent, calib_results, track_results);
    $display("with %0d register writes over %0d random gain settings",
             reg_writes, RandomPhases);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tof_pkg.sv
hdl/tof_if.sv
hdl/tof_alu.sv
hdl/tof_core.sv
hdl/third_order_altitude_fusion.sv
test/tb_third_order_altitude_fusion.sv
